>>> hw/rtl/dhash_pkg.sv
// ----------------------------------------------------------------------------
// dhash_pkg
// Shared widths, luminance weights and helper functions for the difference
// hash block.
// ----------------------------------------------------------------------------
package dhash_pkg;

  localparam int unsigned CompW  = 8;
  localparam int unsigned LumaW  = 24;
  localparam int unsigned HashW  = 64;
  localparam int unsigned CountW = 6;
  localparam int unsigned DistW  = 7;

  // Rec.709 weights scaled by 2^16; they sum to exactly 65536.
  localparam logic [LumaW-1:0] WeightRed   = 24'd13933;
  localparam logic [LumaW-1:0] WeightGreen = 24'd46871;
  localparam logic [LumaW-1:0] WeightBlue  = 24'd4732;

  localparam logic [CountW-1:0] LastPixel = 6'd63;
  localparam logic [DistW-1:0]  HashBits  = 7'd64;

  typedef logic [LumaW-1:0] luma_t;
  typedef logic [HashW-1:0] hash_t;
  typedef logic [DistW-1:0] dist_t;

  // Ones count of one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  // Ones count of a full hash word, formed as a sum of byte counts.
  function automatic dist_t popcount64(input hash_t v);
    dist_t n;
    n = '0;
    for (int b = 0; b < HashW / 8; b++) begin
      n = n + {3'd0, popcount8(v[b*8 +: 8])};
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/dhash_luma.sv
// ----------------------------------------------------------------------------
// dhash_luma
// Two-stage pipeline: registers the incoming pixel, then registers its
// fixed-point luminance. Each stage has its own valid flag and fills
// whenever the stage after it can move.
// ----------------------------------------------------------------------------
module dhash_luma (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dhash_pkg::CompW-1:0] red,
  input  logic [dhash_pkg::CompW-1:0] green,
  input  logic [dhash_pkg::CompW-1:0] blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dhash_pkg::luma_t           luma
);

  logic                        pix_valid;
  logic [dhash_pkg::CompW-1:0] pix_red;
  logic [dhash_pkg::CompW-1:0] pix_green;
  logic [dhash_pkg::CompW-1:0] pix_blue;
  logic                        luma_valid;
  dhash_pkg::luma_t            luma_reg;
  dhash_pkg::luma_t            luma_next;
  logic                        luma_ready;

  assign luma_ready = !luma_valid || out_ready;
  assign in_ready   = !pix_valid || luma_ready;

  // The product is exact: the weighted sum never exceeds 24 bits.
  assign luma_next = dhash_pkg::LumaW'(pix_red)   * dhash_pkg::WeightRed
                   + dhash_pkg::LumaW'(pix_green) * dhash_pkg::WeightGreen
                   + dhash_pkg::LumaW'(pix_blue)  * dhash_pkg::WeightBlue;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid  <= 1'b0;
      luma_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        pix_valid <= in_valid;
      end
      if (luma_ready) begin
        luma_valid <= pix_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_red   <= red;
      pix_green <= green;
      pix_blue  <= blue;
    end
    if (luma_ready && pix_valid) begin
      luma_reg <= luma_next;
    end
  end

  assign out_valid = luma_valid;
  assign luma      = luma_reg;

endmodule

>>> hw/rtl/difference_hash_with_hamming_compare.sv
// ----------------------------------------------------------------------------
// difference_hash_with_hamming_compare
// 64-bit difference hash of an 8x8 RGB image with Hamming comparison.
// ----------------------------------------------------------------------------
// Pixels arrive on the s_axis channel in raster order, 64 per image, one
// transfer each; tdata carries red, green and blue. After the 64th pixel one
// result transfer leaves on m_axis with the hash (first pixel's bit on top),
// its Hamming distance to the reference hash and 64 minus that distance.
// The reference hash is loaded through the cfg channel, which is always
// ready; write it only while no image is in flight.
// Throughput is one pixel per cycle while s_axis_tready is high. A pixel
// passes an input register and a luminance register before it updates the
// hash state; the result then passes a hash register and an output register
// that holds the ones count before m_axis_tvalid rises.
// Reset clears the pixel count, the hash state, all valid flags and the
// reference hash. When the receiver stalls, the result waits in the output
// register, a second result can wait in the hash register, and pixels keep
// flowing until the 64th pixel of a third image finds no free slot; only
// then does s_axis_tready fall.
// ----------------------------------------------------------------------------
module difference_hash_with_hamming_compare (
  input  logic        clk,
  input  logic        rst,
  // tdata fields, lowest bit up: red[7:0], green[15:8], blue[23:16]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields, lowest bit up: image_hash[63:0], distance[70:64],
  // similarity[77:71], zero fill[79:78]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  dhash_pkg::hash_t            reference_hash;
  logic                        l_valid;
  logic                        l_ready;
  dhash_pkg::luma_t            l_luma;
  logic                        consume;
  logic [dhash_pkg::CountW-1:0] pixel_count;
  dhash_pkg::luma_t            prior_luma;
  dhash_pkg::luma_t            first_luma;
  logic [61:0]                 hash_shift;
  logic                        hash_bit;
  logic                        wrap_bit;
  logic                        res_valid;
  logic                        res_ready;
  dhash_pkg::hash_t            res_hash;
  logic                        out_valid;
  dhash_pkg::hash_t            out_hash;
  dhash_pkg::dist_t            out_dist;
  dhash_pkg::dist_t            out_sim;
  dhash_pkg::dist_t            dist_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hash <= '0;
    end else if (cfg_valid) begin
      reference_hash <= cfg_data;
    end
  end

  dhash_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red       (s_axis_tdata[7:0]),
    .green     (s_axis_tdata[15:8]),
    .blue      (s_axis_tdata[23:16]),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .luma      (l_luma)
  );

  assign res_ready = !out_valid || m_axis_tready;
  // Only the last pixel of an image needs room in the hash register.
  assign l_ready   = (pixel_count != dhash_pkg::LastPixel) || !res_valid || res_ready;
  assign consume   = l_valid && l_ready;
  assign hash_bit  = prior_luma >= l_luma;
  assign wrap_bit  = l_luma >= first_luma;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      prior_luma  <= '0;
      first_luma  <= '0;
      hash_shift  <= '0;
    end else if (consume) begin
      pixel_count <= pixel_count + 1'b1;
      prior_luma  <= l_luma;
      if (pixel_count == '0) begin
        first_luma <= l_luma;
        hash_shift <= '0;
      end else if (pixel_count == dhash_pkg::LastPixel) begin
        hash_shift <= '0;
      end else begin
        hash_shift <= {hash_shift[60:0], hash_bit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume && pixel_count == dhash_pkg::LastPixel) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && pixel_count == dhash_pkg::LastPixel) begin
      res_hash <= {wrap_bit, hash_shift, hash_bit};
    end
  end

  assign dist_next = dhash_pkg::popcount64(res_hash ^ reference_hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_hash <= res_hash;
      out_dist <= dist_next;
      out_sim  <= dhash_pkg::HashBits - dist_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_sim, out_dist, out_hash};

  // A pixel that starts an image always leaves a cleared hash and a count of one.
  assert property (@(posedge clk) disable iff (rst)
    consume && pixel_count == '0 |=> hash_shift == '0 && pixel_count == 6'd1)
    else $error("image start did not reset hash state");

  // The last pixel of an image always leaves a pending result.
  assert property (@(posedge clk) disable iff (rst)
    consume && pixel_count == dhash_pkg::LastPixel |=> res_valid && pixel_count == '0)
    else $error("last pixel did not produce a result");

  // A pending result that cannot move keeps its hash.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_hash))
    else $error("blocked result was lost or changed");

  // Distance and similarity always add up to the hash width.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_dist + out_sim) == dhash_pkg::HashBits)
    else $error("distance and similarity disagree");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 64-bit difference hash with Hamming compare.
// Pixels are streamed in 64-pixel images with random gaps on both sides. A
// scoreboard predicts the hash, distance and similarity of every image and
// checks each result transfer against the oldest prediction. The reference
// hash is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

typedef struct {
  dhash_pkg::hash_t image_hash;
  dhash_pkg::dist_t distance;
  dhash_pkg::dist_t similarity;
} hash_result_t;

class result_scoreboard;
  localparam int unsigned RedScale   = 13933;
  localparam int unsigned GreenScale = 46871;
  localparam int unsigned BlueScale  = 4732;

  hash_result_t      expected_q[$];
  dhash_pkg::hash_t  reference_hash;
  int                pixel_index;
  dhash_pkg::luma_t  prior_luma;
  dhash_pkg::luma_t  first_luma;
  dhash_pkg::hash_t  hash_bits;
  dhash_pkg::hash_t  last_hash;
  int                errors;

  function new();
    reference_hash = '0;
    pixel_index    = 0;
    prior_luma     = '0;
    first_luma     = '0;
    hash_bits      = '0;
    last_hash      = '0;
    errors         = 0;
  endfunction

  function void set_reference(dhash_pkg::hash_t value);
    reference_hash = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Called for every accepted pixel transfer.
  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned      sum;
    dhash_pkg::luma_t luma;
    hash_result_t     res;
    sum  = {24'd0, r} * RedScale + {24'd0, g} * GreenScale + {24'd0, b} * BlueScale;
    luma = sum[23:0];
    if (pixel_index == 0) begin
      first_luma  = luma;
      prior_luma  = luma;
      hash_bits   = '0;
      pixel_index = 1;
    end else begin
      hash_bits  = {hash_bits[62:0], prior_luma >= luma};
      prior_luma = luma;
      if (pixel_index == 63) begin
        // The first pixel's bit closes the ring against the last pixel.
        res.image_hash = {luma >= first_luma, hash_bits[62:0]};
        res.distance   = 7'($countones(res.image_hash ^ reference_hash));
        res.similarity = 7'd64 - res.distance;
        expected_q.push_back(res);
        last_hash   = res.image_hash;
        pixel_index = 0;
        hash_bits   = '0;
      end else begin
        pixel_index = pixel_index + 1;
      end
    end
  endfunction

  // Called for every accepted result transfer.
  function void check_result(logic [79:0] word);
    hash_result_t want;
    if (expected_q.size() == 0) begin
      $error("result transfer with no expected result waiting: %h", word);
      errors++;
    end else begin
      want = expected_q.pop_front();
      if (word[63:0] !== want.image_hash) begin
        $error("image_hash mismatch: expected %h, actual %h", want.image_hash, word[63:0]);
        errors++;
      end
      if (word[70:64] !== want.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", want.distance, word[70:64]);
        errors++;
      end
      if (word[77:71] !== want.similarity) begin
        $error("similarity mismatch: expected %0d, actual %0d", want.similarity, word[77:71]);
        errors++;
      end
    end
  endfunction
endclass

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int          HoldCycles = 600;
  localparam int          SettleCycles = 10;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] cfg_data      = '0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;

  result_scoreboard sb;
  logic [23:0]      last_image [64];
  bit               hold_request = 1'b0;
  int unsigned      cycle_count = 0;

  difference_hash_with_hamming_compare uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Picks the next random pixel; many picks stay close to the previous one
  // so that ties and near ties in luminance come up often.
  function automatic logic [23:0] pick_pixel(input logic [23:0] prev);
    logic [23:0] p;
    int          k;
    int          mode;
    p    = prev;
    mode = $urandom_range(0, 9);
    if (mode <= 4) begin
      p = 24'($urandom);
    end else if (mode == 7) begin
      p = {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
           ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
    end else if (mode == 8) begin
      k = $urandom_range(0, 2);
      if (p[k*8 +: 8] == 8'hFF) begin
        p[k*8 +: 8] = p[k*8 +: 8] - 8'd1;
      end else begin
        p[k*8 +: 8] = p[k*8 +: 8] + 8'd1;
      end
    end else if (mode == 9) begin
      p[7:0] = 8'($urandom);
      p      = {p[7:0], p[7:0], p[7:0]};
    end
    return p;
  endfunction

  // Offers one pixel after the given number of idle cycles; returns at the
  // edge of the transfer with tvalid still high.
  task automatic send_pixel(input logic [23:0] px, input int gap);
    bit ready_seen;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    forever begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
      if (ready_seen) break;
    end
    sb.note_pixel(px[7:0], px[15:8], px[23:16]);
  endtask

  task automatic send_image(input bit replay, input bit no_gaps);
    logic [23:0] px;
    px = 24'($urandom);
    for (int i = 0; i < 64; i++) begin
      px = replay ? last_image[i] : pick_pixel(px);
      last_image[i] = px;
      send_pixel(px, no_gaps ? 0 : $urandom_range(0, 12));
    end
  endtask

  task automatic write_reference(input logic [63:0] value);
    bit ready_seen;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
      if (ready_seen) break;
    end
    cfg_valid <= 1'b0;
    sb.set_reference(value);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Result side: random stalls per result, and one long hold on request.
  initial begin
    bit          valid_seen;
    logic [79:0] word;
    int          gap;
    wait (sb != null);
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      forever begin
        @(negedge clk);
        valid_seen = m_axis_tvalid;
        word       = m_axis_tdata;
        @(posedge clk);
        if (valid_seen === 1'b1) break;
      end
      sb.check_result(word);
    end
  end

  initial begin
    logic [63:0] ref_value;
    logic [23:0] px;
    int          images;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Flat black image: every comparison is a tie, so every bit is set and
    // the distance to an all-zero reference is the full 64.
    write_reference(64'd0);
    for (int i = 0; i < 64; i++) begin
      send_pixel(24'h000000, $urandom_range(0, 12));
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // Extreme colors up front, then a rising gray ramp, and a black last
    // pixel so the wrap-around bit comes out clear.
    write_reference('1);
    for (int i = 0; i < 64; i++) begin
      case (i)
        0:       px = 24'hFFFFFF;
        1:       px = 24'h000000;
        2:       px = 24'h0000FF;
        3:       px = 24'h00FF00;
        4:       px = 24'hFF0000;
        63:      px = 24'h000000;
        default: px = {i[7:0], i[7:0], i[7:0]};
      endcase
      last_image[i] = px;
      send_pixel(px, $urandom_range(0, 12));
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      images = 4;
      case (phase)
        0:       ref_value = {$urandom, $urandom};
        1:       ref_value = '1;
        2:       ref_value = {$urandom, $urandom};
        3:       ref_value = sb.last_hash;
        4:       ref_value = ~sb.last_hash;
        default: ref_value = '0;
      endcase
      write_reference(ref_value);
      // The pressure phase streams without gaps while the receiver holds off.
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < images; n++) begin
        send_image(phase >= 3 && phase <= 4 && n == 0,
                   phase == 2 || $urandom_range(0, 3) == 0);
      end
      s_axis_tvalid <= 1'b0;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
